// ===== hdl/rftp_pkg.sv =====
package rftp_pkg;

    localparam int ValueBitsDefault = 32;
    localparam int FieldsPerFrame   = 4;
    localparam int NoKeyValue       = -12345;

    localparam logic [7:0] ChEnd   = 8'h00;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChBar   = 8'h7C;

    // token events for the byte being consumed this cycle
    typedef struct packed {
        logic field_close;
        logic rec_close;
        logic text_end;
    } tok_ctl_t;

endpackage

// ===== hdl/rftp_byte_if.sv =====
interface rftp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== hdl/rftp_frame_if.sv =====
interface rftp_frame_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] abs_time;
    logic signed [31:0] cursor_x;
    logic signed [31:0] cursor_y;
    logic signed [31:0] key_state;
    logic               press_flag;

    modport source (output valid, output abs_time, output cursor_x, output cursor_y,
                    output key_state, output press_flag, input ready);
    modport sink   (input valid, input abs_time, input cursor_x, input cursor_y,
                    input key_state, input press_flag, output ready);
endinterface

// ===== hdl/rftp_token.sv =====
module rftp_token #(
    parameter int VALUE_BITS = rftp_pkg::ValueBitsDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             text_byte,
    output rftp_pkg::tok_ctl_t     ctl,
    output logic [VALUE_BITS-1:0]  field_value
);
    import rftp_pkg::*;

    typedef enum logic [6:0] {
        PH_OUT   = 7'b0000001,
        PH_WS    = 7'b0000010,
        PH_PLUS  = 7'b0000100,
        PH_MINUS = 7'b0001000,
        PH_DPOS  = 7'b0010000,
        PH_DNEG  = 7'b0100000,
        PH_STOP  = 7'b1000000
    } phase_t;

    localparam logic [VALUE_BITS-1:0] VSign     = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VMax      = ~VSign;
    localparam logic [VALUE_BITS+3:0] VSignWide = {4'b0000, VSign};
    // at full 64-bit width the stopped-sign flag shares the top magnitude bit
    localparam bit                    TopShared = (VALUE_BITS == 64);

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   accum_reg, accum_next;
    logic                    neg_reg, neg_next;

    logic                    is_delim, is_digit, is_space;
    logic [3:0]              digit;
    logic [VALUE_BITS+3:0]   prod;
    logic [VALUE_BITS-1:0]   acc_step, sat_accum;

    always_comb
    begin
        is_delim = (text_byte == ChEnd) || (text_byte == ChComma) || (text_byte == ChBar);
        is_digit = text_byte inside {[ChZero:ChNine]};
        is_space = (text_byte == ChSpace) || (text_byte inside {[ChTab:ChCr]});
        digit    = text_byte[3:0];

        // accum*10 + d, saturating at VSign
        prod = ({4'b0000, accum_reg} << 3) + ({4'b0000, accum_reg} << 1)
             + (VALUE_BITS+4)'(digit);
        acc_step  = (prod > VSignWide) ? VSign : prod[VALUE_BITS-1:0];
        sat_accum = accum_reg[VALUE_BITS-1] ? VMax : accum_reg;
    end

    always_comb
    begin
        case (phase_reg)
            PH_MINUS, PH_DNEG: field_value = -accum_reg;
            PH_STOP:
            begin
                if (TopShared && accum_reg[VALUE_BITS-1])
                    field_value = '0;
                else if (neg_reg)
                    field_value = -accum_reg;
                else
                    field_value = sat_accum;
            end
            default: field_value = sat_accum;
        endcase

        ctl.field_close = step && is_delim && (phase_reg != PH_OUT);
        ctl.rec_close   = step && ((text_byte == ChComma) || (text_byte == ChEnd));
        ctl.text_end    = step && (text_byte == ChEnd);
    end

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        if (is_delim)
        begin
            phase_next = PH_OUT;
            accum_next = '0;
            neg_next   = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_OUT, PH_WS:
                begin
                    if (is_space)
                        phase_next = PH_WS;
                    else if (text_byte == ChPlus)
                        phase_next = PH_PLUS;
                    else if (text_byte == ChMinus)
                        phase_next = PH_MINUS;
                    else if (is_digit)
                    begin
                        accum_next = VALUE_BITS'(digit);
                        phase_next = PH_DPOS;
                    end
                    else
                    begin
                        accum_next = '0;
                        phase_next = PH_STOP;
                    end
                end
                PH_PLUS, PH_MINUS, PH_DPOS, PH_DNEG:
                begin
                    if (is_digit)
                    begin
                        accum_next = acc_step;
                        phase_next = ((phase_reg == PH_PLUS) || (phase_reg == PH_DPOS))
                                   ? PH_DPOS : PH_DNEG;
                    end
                    else
                    begin
                        neg_next   = (phase_reg == PH_MINUS) || (phase_reg == PH_DNEG);
                        accum_next = ((phase_reg == PH_PLUS) || (phase_reg == PH_MINUS))
                                   ? '0 : accum_reg;
                        phase_next = PH_STOP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OUT;
            accum_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ===== hdl/replay_frame_text_parser.sv =====
// Path: the closing byte of a record is held in the input register, then its result
// is written to the result register.
// Throughput: one text byte per cycle; a full result register stalls the input
// register, which still takes one more byte.
// Reset (rst_n, async, active low) clears parse state, running time, previous key
// and both valid flags.
module replay_frame_text_parser #(
    parameter int VALUE_BITS = rftp_pkg::ValueBitsDefault
) (
    input logic         clk,
    input logic         rst_n,
    rftp_byte_if.sink   text,
    rftp_frame_if.source frame
);
    import rftp_pkg::*;

    localparam int                    CountBits = $clog2(FieldsPerFrame + 1);
    localparam int                    IdxBits   = $clog2(FieldsPerFrame);
    localparam logic [CountBits-1:0]  CountFull = CountBits'(FieldsPerFrame);
    localparam logic [VALUE_BITS-1:0] NoKey     = VALUE_BITS'(NoKeyValue);

    logic                   byte_valid_reg;
    logic [7:0]             byte_reg;
    logic                   out_valid_reg;
    logic signed [31:0]     abs_time_reg, cursor_x_reg, cursor_y_reg, key_state_reg;
    logic                   press_reg;

    logic [VALUE_BITS-1:0]  time_reg, prev_key_reg;
    logic [CountBits-1:0]   count_reg;
    logic [VALUE_BITS-1:0]  fv_reg [FieldsPerFrame];

    logic                   out_free, step, room, emit, rec_full;
    tok_ctl_t               tok_ctl;
    logic [VALUE_BITS-1:0]  field_value;
    logic [VALUE_BITS-1:0]  fv_eff [FieldsPerFrame];
    logic [CountBits-1:0]   count_eff;
    logic [VALUE_BITS-1:0]  key, time_sum;

    assign out_free   = !out_valid_reg || frame.ready;
    assign step       = byte_valid_reg && out_free;
    assign text.ready = !byte_valid_reg || out_free;

    rftp_token #(.VALUE_BITS(VALUE_BITS)) u_token (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (byte_reg),
        .ctl         (tok_ctl),
        .field_value (field_value)
    );

    always_comb
    begin
        room = count_reg < CountFull;
        for (int i = 0; i < FieldsPerFrame; i++)
        begin
            fv_eff[i] = (tok_ctl.field_close && (count_reg == CountBits'(i)))
                      ? field_value : fv_reg[i];
        end
        count_eff = count_reg + CountBits'(tok_ctl.field_close && room);
        rec_full  = (count_eff == CountFull);
        key       = fv_eff[FieldsPerFrame-1];
        time_sum  = time_reg + fv_eff[0];
        emit      = tok_ctl.rec_close && rec_full && (key != NoKey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            time_reg       <= '0;
            prev_key_reg   <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (text.valid && text.ready)
                byte_valid_reg <= 1'b1;
            else if (step)
                byte_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= emit;
            else if (frame.ready)
                out_valid_reg <= 1'b0;

            if (step)
            begin
                if (tok_ctl.rec_close)
                begin
                    count_reg <= '0;
                    if (tok_ctl.text_end)
                    begin
                        time_reg     <= '0;
                        prev_key_reg <= '0;
                    end
                    else if (rec_full)
                    begin
                        time_reg     <= time_sum;
                        prev_key_reg <= key;
                    end
                end
                else if (tok_ctl.field_close && room)
                begin
                    count_reg <= count_reg + CountBits'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
            byte_reg <= text.text_byte;
        if (step && tok_ctl.field_close && room && !tok_ctl.rec_close)
            fv_reg[count_reg[IdxBits-1:0]] <= field_value;
        if (step && emit)
        begin
            abs_time_reg  <= 32'(signed'(time_sum));
            cursor_x_reg  <= 32'(signed'(fv_eff[1]));
            cursor_y_reg  <= 32'(signed'(fv_eff[2]));
            key_state_reg <= 32'(signed'(key));
            press_reg     <= (key != prev_key_reg);
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.abs_time   = abs_time_reg;
    assign frame.cursor_x   = cursor_x_reg;
    assign frame.cursor_y   = cursor_y_reg;
    assign frame.key_state  = key_state_reg;
    assign frame.press_flag = press_reg;

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && tok_ctl.text_end |=> (time_reg == '0) && (prev_key_reg == '0))
        else $error("running time or previous key not cleared at end of text");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountFull)
        else $error("field count beyond record size");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a consumed item");

    a_no_result_mid_field: assert property (@(posedge clk) disable iff (!rst_n)
        step && !tok_ctl.rec_close |=> !out_valid_reg)
        else $error("result produced by a byte that does not close a record");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rftp_pkg::*;

    localparam int ItemsTarget = 1650;
    localparam int StallLimit  = 2000;
    localparam int TailCycles  = 12;
    localparam int SideText    = 0;
    localparam int SideFrame   = 1;
    localparam logic [63:0] SignMag = 64'h0000_0000_8000_0000;
    localparam logic [31:0] MaxPos  = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        TokOut, TokSpace, TokPlus, TokMinus, TokPosDig, TokNegDig, TokStopped
    } tok_phase_t;

    typedef struct packed {
        logic [31:0] abs_time;
        logic [31:0] cursor_x;
        logic [31:0] cursor_y;
        logic [31:0] key_state;
        logic        press_flag;
    } frame_t;

    class frame_scoreboard;
        logic [31:0] run_time;
        logic [31:0] last_key;
        int unsigned n_fields;
        logic [31:0] fld[4];
        logic [63:0] mag;
        tok_phase_t  phase;
        frame_t      pending_frames[$];
        int          errors;

        function new();
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            run_time = '0;
            last_key = '0;
            n_fields = 0;
            for (int i = 0; i < 4; i++) fld[i] = '0;
            mag   = '0;
            phase = TokOut;
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == ChSpace || (c >= ChTab && c <= ChCr);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= ChZero && c <= ChNine;
        endfunction

        function void close_token();
            logic [31:0] v;
            logic [63:0] m;
            if (phase == TokOut)
                return;
            case (phase)
                TokMinus, TokNegDig: v = -mag[31:0];
                TokStopped:
                begin
                    // bit 63 carries the sign of a token that hit junk
                    m = {1'b0, mag[62:0]};
                    if (mag[63])
                        v = -m[31:0];
                    else
                        v = (m > {32'd0, MaxPos}) ? MaxPos : m[31:0];
                end
                default: v = (mag > {32'd0, MaxPos}) ? MaxPos : mag[31:0];
            endcase
            if (n_fields < FieldsPerFrame)
            begin
                fld[n_fields] = v;
                n_fields++;
            end
            phase = TokOut;
            mag   = '0;
        endfunction

        function void close_record();
            frame_t f;
            close_token();
            if (n_fields >= FieldsPerFrame)
            begin
                run_time = run_time + fld[0];
                if (fld[3] != 32'(NoKeyValue))
                begin
                    f = {run_time, fld[1], fld[2], fld[3], fld[3] != last_key};
                    pending_frames = {pending_frames, f};
                end
                last_key = fld[3];
            end
            n_fields = 0;
            for (int i = 0; i < 4; i++) fld[i] = '0;
        endfunction

        function void note_byte(logic [7:0] c);
            logic [63:0] d;
            logic [63:0] m;
            logic        neg;
            if (c == ChEnd)
            begin
                close_record();
                clear_text();
            end
            else if (c == ChComma)
                close_record();
            else if (c == ChBar)
                close_token();
            else
            begin
                case (phase)
                    TokOut, TokSpace:
                    begin
                        if (is_ws(c))
                            phase = TokSpace;
                        else if (c == ChPlus)
                            phase = TokPlus;
                        else if (c == ChMinus)
                            phase = TokMinus;
                        else if (is_digit(c))
                        begin
                            mag   = 64'(c - ChZero);
                            phase = TokPosDig;
                        end
                        else
                        begin
                            mag   = '0;
                            phase = TokStopped;
                        end
                    end
                    TokPlus, TokMinus, TokPosDig, TokNegDig:
                    begin
                        neg = (phase == TokMinus || phase == TokNegDig);
                        if (is_digit(c))
                        begin
                            d = 64'(c - ChZero);
                            if (mag > (SignMag - d) / 10)
                                mag = SignMag;
                            else
                                mag = mag * 10 + d;
                            phase = neg ? TokNegDig : TokPosDig;
                        end
                        else
                        begin
                            m = (phase == TokPlus || phase == TokMinus) ? 64'd0 : mag;
                            if (m > SignMag)
                                m = SignMag;
                            mag   = m | {neg, 63'd0};
                            phase = TokStopped;
                        end
                    end
                    default: ;
                endcase
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d (%h), want %0d (%h)", what,
                     $signed(got), got, $signed(want), want);
            errors++;
        endtask

        task check_frame(frame_t got);
            frame_t want;
            if (pending_frames.size() == 0)
            begin
                report("frame with none outstanding, abs_time", got.abs_time, 32'd0);
                return;
            end
            want = pending_frames.pop_front();
            if (got.abs_time !== want.abs_time)
                report("abs_time", got.abs_time, want.abs_time);
            if (got.cursor_x !== want.cursor_x)
                report("cursor_x", got.cursor_x, want.cursor_x);
            if (got.cursor_y !== want.cursor_y)
                report("cursor_y", got.cursor_y, want.cursor_y);
            if (got.key_state !== want.key_state)
                report("key_state", got.key_state, want.key_state);
            if (got.press_flag !== want.press_flag)
                report("press_flag", 32'(got.press_flag), 32'(want.press_flag));
        endtask
    endclass

    logic clk;
    logic rst_n;

    rftp_byte_if  text_ch();
    rftp_frame_if frame_ch();

    replay_frame_text_parser u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .frame (frame_ch)
    );

    frame_scoreboard sb;
    frame_t          seen;
    logic [7:0]      text_q[$];
    int              bytes_sent;
    int              idle_cycles;
    int              calm_left[2];
    bit              draining;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap lengths: mostly none or short, a few long, with calm stretches
    function automatic int pick_gap(input int side);
        int r;
        if (side == SideFrame && draining)
            return 0;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            calm_left[side] = $urandom_range(40, 150);
            return 0;
        end
        if (r < 110)
            return 0;
        if (r < 170)
            return $urandom_range(1, 3);
        if (r < 194)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic add_token();
        int          r;
        int unsigned u;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                put_byte($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13)));
        r = $urandom_range(0, 9);
        if (r < 2)
            put_byte(ChMinus);
        else if (r == 2)
            put_byte(ChPlus);
        r = $urandom_range(0, 99);
        if (r < 55)
            add_str($sformatf("%0d", $urandom_range(0, 99999)));
        else if (r < 75)
        begin
            u = $urandom;
            add_str($sformatf("%0d", u));
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0: add_str("2147483647");
                1: add_str("2147483648");
                2: add_str("2147483649");
                3: add_str("99999999999999999999");
                default: add_str("0000000000012");
            endcase
        end
        else if (r < 92)
        begin
            // sign only, whitespace only or a word
            if ($urandom_range(0, 1))
                add_str("ab");
        end
        else
            put_byte(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 99) < 15)
            add_str($sformatf(".%0d", $urandom_range(0, 999)));
        if ($urandom_range(0, 99) < 6)
            put_byte(8'($urandom_range(33, 255)));
    endtask

    task automatic add_field(input int slot);
        int r;
        r = $urandom_range(0, 99);
        if (slot == 3 && r < 12)
            add_str("-12345");
        else if (slot == 3 && r < 75)
            add_str($sformatf("%0d", $urandom_range(0, 4)));   // small keys repeat often
        else if (slot == 0 && r < 60)
            add_str($sformatf("%0d", $urandom_range(0, 300)));
        else
            add_token();
    endtask

    task automatic add_record();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            repeat ($urandom_range(2, 10))
                put_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (r < 82)
            n = 4;
        else if (r < 89)
            n = 3;
        else if (r < 95)
            n = $urandom_range(5, 6);
        else
            n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                put_byte(ChBar);
                if ($urandom_range(0, 19) == 0)
                    put_byte(ChBar);
            end
            add_field(i);
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            put_byte(ChEnd);
        else
        begin
            put_byte(ChComma);
            if (r < 7)
                put_byte(ChComma);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(SideText);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_queue();
        while (text_q.size() > 0)
            send_byte(text_q.pop_front());
    endtask

    // sink side: random stalls on ready
    initial
    begin
        int hold;
        int st;
        frame_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            frame_ch.ready <= 1'b1;
            hold = $urandom_range(1, 12);
            repeat (hold) @(posedge clk);
            st = pick_gap(SideFrame);
            if (st > 0)
            begin
                frame_ch.ready <= 1'b0;
                repeat (st) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
            sb.note_byte(text_ch.text_byte);
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            seen = {frame_ch.abs_time, frame_ch.cursor_x, frame_ch.cursor_y,
                    frame_ch.key_state, frame_ch.press_flag};
            sb.check_frame(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (frame_ch.valid && frame_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit)
        begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        sb                = new();
        bytes_sent        = 0;
        idle_cycles       = 0;
        calm_left[0]      = 0;
        calm_left[1]      = 0;
        draining          = 1'b0;
        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= ChEnd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // leading empty record and token, truncated decimal, fifth field of a high byte,
        // empty and whitespace-only fields, word and sign-only tokens, end of text
        add_str(",|1|-2|3.7|5|");
        put_byte(8'hFF);
        add_str(",9|| |x|-");
        put_byte(ChEnd);
        send_queue();

        while (bytes_sent < ItemsTarget)
        begin
            add_record();
            send_queue();
        end
        text_ch.valid <= 1'b0;
        draining = 1'b1;

        while (sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (sb.errors == 0 && sb.pending_frames.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== replay_frame_text_parser.f =====
hdl/rftp_pkg.sv
hdl/rftp_byte_if.sv
hdl/rftp_frame_if.sv
hdl/rftp_token.sv
hdl/replay_frame_text_parser.sv
tb/sv/tb_top.sv
